// ===== src/mcspg_pkg.sv =====
// shared types and constants for the multi-channel servo pulse generator
// no dependencies; every other file of the block uses this package
`timescale 1ns / 1ps

package mcspg_pkg;

  // channel count and field widths
  localparam int CHANNELS    = 8;
  localparam int CHANNEL_W   = 3;
  localparam int SLOTS       = 1 << CHANNEL_W;
  localparam int WIDTH_W     = 8;
  localparam int FRAME_W     = 12;
  localparam int VALUE_W     = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int DIVIDEND_W  = 16;
  localparam int DIV_COUNT_W = $clog2(DIVIDEND_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // channels that physically exist
  localparam logic [SLOTS-1:0] CHAN_MASK = SLOTS'((64'd1 << CHANNELS) - 64'd1);

  // arithmetic constants
  localparam logic [WIDTH_W-1:0] FULL_ANGLE    = 8'd180;
  localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH = 8'd93;
  localparam logic [WIDTH_W-1:0] WIDTH_SAT     = 8'd255;

  // x/180 for a 16-bit x as ((x >> 2) * 11651) >> 19, exact over the whole range
  localparam int                 RECIP_W      = DIVIDEND_W - 2;
  localparam int                 RECIP_PROD_W = 2 * RECIP_W;
  localparam int                 RECIP_SHIFT  = 19;
  localparam logic [RECIP_W-1:0] ANGLE_RECIP  = 14'd11651;

  // register reset values
  localparam logic [WIDTH_W-1:0] MIN_TICKS_RESET   = 8'd34;
  localparam logic [WIDTH_W-1:0] MAX_TICKS_RESET   = 8'd150;
  localparam logic [SLOTS-1:0]   ENABLE_MASK_RESET = '0;
  localparam logic [FRAME_W-1:0] FRAME_TICKS_RESET = 12'd1280;

  // operation codes
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_ANGLE  = 2'd1,
    OP_SET_TICKS  = 2'd2,
    OP_READ_ANGLE = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_TICKS   = 2'd0,
    REG_MAX_TICKS   = 2'd1,
    REG_ENABLE_MASK = 2'd2,
    REG_FRAME_TICKS = 2'd3
  } cfg_reg_t;

  // classified command as held in the queue
  typedef struct packed {
    op_t                  op;
    logic [CHANNEL_W-1:0] channel;
    logic                 chan_ok;
    logic [WIDTH_W-1:0]   arg;
  } cmd_t;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [WIDTH_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_PREP = 2'd1,
    BK_DIV  = 2'd2,
    BK_DONE = 2'd3
  } bk_state_t;

endpackage

// ===== src/mcspg_front.sv =====
// front end: takes input transactions and classifies them into queue commands
// depends on mcspg_pkg
`timescale 1ns / 1ps

module mcspg_front (
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic [mcspg_pkg::CHANNEL_W-1:0]     channel,
  input  logic signed [mcspg_pkg::VALUE_W-1:0] value,
  input  logic                                q_full,
  output logic                                push,
  output mcspg_pkg::cmd_t                     cmd
);

  mcspg_pkg::op_t                   op;
  logic [mcspg_pkg::WIDTH_W-1:0]    angle_arg;
  logic [mcspg_pkg::WIDTH_W-1:0]    ticks_arg;

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign op       = mcspg_pkg::op_t'(operation);

  // angle clamped to 0..180
  always_comb begin
    if (value[mcspg_pkg::VALUE_W-1]) begin
      angle_arg = '0;
    end else if ($unsigned(value) > mcspg_pkg::VALUE_W'(mcspg_pkg::FULL_ANGLE)) begin
      angle_arg = mcspg_pkg::FULL_ANGLE;
    end else begin
      angle_arg = value[mcspg_pkg::WIDTH_W-1:0];
    end
  end

  // raw width saturated to 0..255, the min/max clamp follows in the back end
  always_comb begin
    if (value[mcspg_pkg::VALUE_W-1]) begin
      ticks_arg = '0;
    end else if (value[mcspg_pkg::VALUE_W-2:mcspg_pkg::WIDTH_W] != '0) begin
      ticks_arg = mcspg_pkg::WIDTH_SAT;
    end else begin
      ticks_arg = value[mcspg_pkg::WIDTH_W-1:0];
    end
  end

  // build the command
  always_comb begin
    cmd.op      = op;
    cmd.channel = channel;
    cmd.chan_ok = ({1'b0, channel} < (mcspg_pkg::CHANNEL_W + 1)'(mcspg_pkg::CHANNELS));
    case (op)
      mcspg_pkg::OP_SET_ANGLE: cmd.arg = angle_arg;
      mcspg_pkg::OP_SET_TICKS: cmd.arg = ticks_arg;
      default:                 cmd.arg = '0;
    endcase
  end

endmodule

// ===== src/mcspg_queue.sv =====
// short command queue between front and back end
// depends on mcspg_pkg
`timescale 1ns / 1ps

module mcspg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mcspg_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mcspg_pkg::cmd_t head
);

  mcspg_pkg::cmd_t                   entries [mcspg_pkg::QUEUE_DEPTH];
  logic [mcspg_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mcspg_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mcspg_pkg::QPTR_W:0]        count;

  assign full       = (count == (mcspg_pkg::QPTR_W + 1)'(mcspg_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mcspg_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mcspg_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (mcspg_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (mcspg_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/mcspg_div.sv =====
// restoring divider, one quotient bit per cycle, 16-bit dividend by 8-bit divisor
// depends on mcspg_pkg
`timescale 1ns / 1ps

module mcspg_div (
  input  logic                clk,
  input  logic                rst,
  input  mcspg_pkg::div_req_t req,
  output mcspg_pkg::div_rsp_t rsp
);

  logic                                 busy;
  logic                                 done;
  logic [mcspg_pkg::DIV_COUNT_W-1:0]    cnt;
  logic [mcspg_pkg::DIVIDEND_W-1:0]     dq;
  logic [mcspg_pkg::WIDTH_W-1:0]        rem;
  logic [mcspg_pkg::WIDTH_W-1:0]        divisor;
  logic [mcspg_pkg::WIDTH_W:0]          rem_sh;
  logic                                 ge;
  logic [mcspg_pkg::WIDTH_W-1:0]        rem_next;

  // one shift-subtract step
  always_comb begin
    rem_sh = {rem, dq[mcspg_pkg::DIVIDEND_W-1]};
    ge     = (rem_sh >= {1'b0, divisor});
    if (ge) begin
      rem_next = mcspg_pkg::WIDTH_W'(rem_sh - {1'b0, divisor});
    end else begin
      rem_next = rem_sh[mcspg_pkg::WIDTH_W-1:0];
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + mcspg_pkg::DIV_COUNT_W'(1);
        if (cnt == mcspg_pkg::DIV_COUNT_W'(mcspg_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      dq  <= {dq[mcspg_pkg::DIVIDEND_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

// ===== src/mcspg_back.sv =====
// back end: executes queued commands, holds pulse widths, pins, frame count
// and the output register; depends on mcspg_pkg and drives mcspg_div
`timescale 1ns / 1ps

module mcspg_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  mcspg_pkg::cmd_t                   q_head,
  output logic                              q_pop,
  input  logic [mcspg_pkg::WIDTH_W-1:0]     min_ticks,
  input  logic [mcspg_pkg::WIDTH_W-1:0]     max_ticks,
  input  logic [mcspg_pkg::SLOTS-1:0]       enable_mask,
  input  logic [mcspg_pkg::FRAME_W-1:0]     frame_ticks,
  output mcspg_pkg::div_req_t               div_req,
  input  mcspg_pkg::div_rsp_t               div_rsp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcspg_pkg::SLOTS-1:0]       pin_levels,
  output logic [mcspg_pkg::WIDTH_W-1:0]     read_angle,
  output mcspg_pkg::bk_state_t              state
);

  mcspg_pkg::bk_state_t                 state_next;
  mcspg_pkg::cmd_t                      cmd;
  logic                                 use_q;
  logic [mcspg_pkg::WIDTH_W-1:0]        pulse_width [mcspg_pkg::SLOTS];
  logic [mcspg_pkg::SLOTS-1:0]          pin_high;
  logic [mcspg_pkg::FRAME_W-1:0]        frame_count;

  logic                                 out_free;
  logic                                 finish;
  logic                                 need_div;
  logic signed [mcspg_pkg::WIDTH_W:0]   span;
  logic                                 span_neg;
  logic [mcspg_pkg::WIDTH_W-1:0]        span_abs;
  logic [mcspg_pkg::WIDTH_W-1:0]        pw_sel;
  logic [mcspg_pkg::WIDTH_W+1:0]        num;
  logic                                 num_pos;
  logic [mcspg_pkg::WIDTH_W:0]          mul_a;
  logic [mcspg_pkg::WIDTH_W-1:0]        mul_b;
  logic [mcspg_pkg::DIVIDEND_W-1:0]     product;
  logic [mcspg_pkg::RECIP_PROD_W-1:0]   recip_prod;
  logic [mcspg_pkg::WIDTH_W-1:0]        angle_q;
  logic [mcspg_pkg::WIDTH_W-1:0]        q8;
  logic signed [mcspg_pkg::WIDTH_W+1:0] angle_w;
  logic [mcspg_pkg::WIDTH_W-1:0]        angle_width;
  logic [mcspg_pkg::WIDTH_W-1:0]        ticks_width;
  logic [mcspg_pkg::WIDTH_W-1:0]        read_result;
  logic [mcspg_pkg::SLOTS-1:0]          active;
  logic [mcspg_pkg::SLOTS-1:0]          tick_pins;
  logic [mcspg_pkg::FRAME_W:0]          count_inc;
  logic [mcspg_pkg::FRAME_W-1:0]        tick_count;

  assign out_free = !out_valid || !out_stall;

  // span and read numerator
  always_comb begin
    span     = $signed({1'b0, max_ticks}) - $signed({1'b0, min_ticks});
    span_neg = span[mcspg_pkg::WIDTH_W];
    span_abs = span_neg ? mcspg_pkg::WIDTH_W'(-span) : span[mcspg_pkg::WIDTH_W-1:0];
    pw_sel   = pulse_width[cmd.channel];
    num      = {2'b00, pw_sel} + (mcspg_pkg::WIDTH_W + 2)'(1) - {2'b00, min_ticks};
    num_pos  = !num[mcspg_pkg::WIDTH_W+1] && (num != '0);
  end

  // operand product: angle*|span| for set angle, (width+1-min)*180 divided by span for reads
  always_comb begin
    need_div = cmd.chan_ok && (cmd.op == mcspg_pkg::OP_READ_ANGLE) &&
               !span_neg && (span != '0) && num_pos;
    if (cmd.op == mcspg_pkg::OP_SET_ANGLE) begin
      mul_a = {1'b0, cmd.arg};
      mul_b = span_abs;
    end else begin
      mul_a = num[mcspg_pkg::WIDTH_W:0];
      mul_b = mcspg_pkg::FULL_ANGLE;
    end
    div_req.dividend = mcspg_pkg::DIVIDEND_W'(
        {{(mcspg_pkg::DIVIDEND_W - mcspg_pkg::WIDTH_W - 1){1'b0}}, mul_a} *
        {{(mcspg_pkg::DIVIDEND_W - mcspg_pkg::WIDTH_W){1'b0}}, mul_b});
    div_req.divisor  = span[mcspg_pkg::WIDTH_W-1:0];
    div_req.start    = (state == mcspg_pkg::BK_PREP) && need_div;
  end

  // set angle: captured product divided by 180 through a reciprocal multiply
  always_comb begin
    recip_prod = mcspg_pkg::RECIP_PROD_W'(product[mcspg_pkg::DIVIDEND_W-1:2]) *
                 mcspg_pkg::RECIP_PROD_W'(mcspg_pkg::ANGLE_RECIP);
    angle_q    = recip_prod[mcspg_pkg::RECIP_SHIFT +: mcspg_pkg::WIDTH_W];
  end

  // results of set and read operations
  always_comb begin
    if (div_rsp.quotient[mcspg_pkg::DIVIDEND_W-1:mcspg_pkg::WIDTH_W] != '0) begin
      q8 = mcspg_pkg::WIDTH_SAT;
    end else begin
      q8 = div_rsp.quotient[mcspg_pkg::WIDTH_W-1:0];
    end
    if (span_neg) begin
      angle_w = $signed({2'b00, min_ticks}) - $signed({2'b00, angle_q});
    end else begin
      angle_w = $signed({2'b00, min_ticks}) + $signed({2'b00, angle_q});
    end
    if (angle_w < $signed({2'b00, min_ticks})) begin
      angle_width = min_ticks;
    end else if (angle_w > $signed({2'b00, max_ticks})) begin
      angle_width = max_ticks;
    end else begin
      angle_width = angle_w[mcspg_pkg::WIDTH_W-1:0];
    end
    if (cmd.arg < min_ticks) begin
      ticks_width = min_ticks;
    end else if (cmd.arg > max_ticks) begin
      ticks_width = max_ticks;
    end else begin
      ticks_width = cmd.arg;
    end
    read_result = use_q ? q8 : '0;
  end

  // tick: rise at count zero, fall at pulse width, low outside the window
  always_comb begin
    active    = enable_mask & mcspg_pkg::CHAN_MASK;
    tick_pins = (frame_count == '0) ? active : pin_high;
    if (frame_count[mcspg_pkg::FRAME_W-1:mcspg_pkg::WIDTH_W] == '0) begin
      for (int k = 0; k < mcspg_pkg::SLOTS; k++) begin
        if (tick_pins[k] && (frame_count[mcspg_pkg::WIDTH_W-1:0] >= pulse_width[k])) begin
          tick_pins[k] = 1'b0;
        end
      end
    end else begin
      tick_pins = '0;
    end
    tick_pins = tick_pins & active;
    count_inc = {1'b0, frame_count} + (mcspg_pkg::FRAME_W + 1)'(1);
    if (count_inc >= {1'b0, frame_ticks}) begin
      tick_count = '0;
    end else begin
      tick_count = count_inc[mcspg_pkg::FRAME_W-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    finish     = 1'b0;
    case (state)
      mcspg_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = mcspg_pkg::BK_PREP;
        end
      end
      mcspg_pkg::BK_PREP: begin
        state_next = need_div ? mcspg_pkg::BK_DIV : mcspg_pkg::BK_DONE;
      end
      mcspg_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_next = mcspg_pkg::BK_DONE;
        end
      end
      mcspg_pkg::BK_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = mcspg_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = mcspg_pkg::BK_IDLE;
      end
    endcase
  end

  // state, pins, widths, frame count and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mcspg_pkg::BK_IDLE;
      out_valid   <= 1'b0;
      pin_high    <= '0;
      frame_count <= '0;
      for (int k = 0; k < mcspg_pkg::SLOTS; k++) begin
        pulse_width[k] <= mcspg_pkg::DEFAULT_WIDTH;
      end
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
        case (cmd.op)
          mcspg_pkg::OP_TICK: begin
            pin_high    <= tick_pins;
            frame_count <= tick_count;
          end
          mcspg_pkg::OP_SET_ANGLE: begin
            if (cmd.chan_ok) begin
              pulse_width[cmd.channel] <= angle_width;
            end
          end
          mcspg_pkg::OP_SET_TICKS: begin
            if (cmd.chan_ok) begin
              pulse_width[cmd.channel] <= ticks_width;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // command register, captured product and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
    if (state == mcspg_pkg::BK_PREP) begin
      use_q   <= need_div;
      product <= div_req.dividend;
    end
    if (finish) begin
      pin_levels <= (cmd.op == mcspg_pkg::OP_TICK) ? tick_pins : pin_high;
      read_angle <= (cmd.op == mcspg_pkg::OP_READ_ANGLE) ? read_result : '0;
    end
  end

endmodule

// ===== src/multi_channel_servo_pulse_generator_top.sv =====
// top level of the multi-channel servo pulse generator: config registers,
// front end, command queue, back end and divider; depends on mcspg_pkg
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_stall) carries operation, channel and value:
//   tick, set angle, set ticks or read angle. Every transaction returns
//   exactly one result on the output channel (out_valid/out_stall) with the
//   pin levels after the operation and, for a read, the angle in degrees.
//   Config registers (min_ticks, max_ticks, enable_mask, frame_ticks) are
//   written through cfg_write/cfg_index/cfg_data; the user must write them
//   while no transaction is in flight, which the block does not enforce.
//   Timing: a tick, set-angle, set-ticks or a read that needs no division
//   passes from the queue through the back end states idle, prep and done
//   into the output register; a read-angle that divides also waits in the
//   div state on the 16-step bit-serial divider. One command is executed at
//   a time, the next only after the last result is registered; the two-entry
//   queue keeps accepting while the back end works or its result waits.
//   Reset: all pins low, frame count zero, every pulse width 93 ticks,
//   registers at their defaults, queue and output empty.
//   Output stall: the result holds in the output register, the back end
//   waits with its next result, and once the queue fills in_stall rises.
module multi_channel_servo_pulse_generator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic [mcspg_pkg::CHANNEL_W-1:0]      channel,
  input  logic signed [mcspg_pkg::VALUE_W-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mcspg_pkg::SLOTS-1:0]          pin_levels,
  output logic [mcspg_pkg::WIDTH_W-1:0]        read_angle,
  input  logic                                 cfg_write,
  input  logic [mcspg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mcspg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [mcspg_pkg::WIDTH_W-1:0]  min_ticks;
  logic [mcspg_pkg::WIDTH_W-1:0]  max_ticks;
  logic [mcspg_pkg::SLOTS-1:0]    enable_mask;
  logic [mcspg_pkg::FRAME_W-1:0]  frame_ticks;

  logic                           push;
  mcspg_pkg::cmd_t                push_cmd;
  logic                           q_full;
  logic                           q_pop;
  logic                           q_valid;
  mcspg_pkg::cmd_t                q_head;
  mcspg_pkg::div_req_t            div_req;
  mcspg_pkg::div_rsp_t            div_rsp;
  mcspg_pkg::bk_state_t           bk_state;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_ticks   <= mcspg_pkg::MIN_TICKS_RESET;
      max_ticks   <= mcspg_pkg::MAX_TICKS_RESET;
      enable_mask <= mcspg_pkg::ENABLE_MASK_RESET;
      frame_ticks <= mcspg_pkg::FRAME_TICKS_RESET;
    end else if (cfg_write) begin
      case (mcspg_pkg::cfg_reg_t'(cfg_index))
        mcspg_pkg::REG_MIN_TICKS:   min_ticks   <= cfg_data[mcspg_pkg::WIDTH_W-1:0];
        mcspg_pkg::REG_MAX_TICKS:   max_ticks   <= cfg_data[mcspg_pkg::WIDTH_W-1:0];
        mcspg_pkg::REG_ENABLE_MASK: enable_mask <= cfg_data[mcspg_pkg::SLOTS-1:0];
        mcspg_pkg::REG_FRAME_TICKS: frame_ticks <= cfg_data[mcspg_pkg::FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front end
  mcspg_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .channel   (channel),
    .value     (value),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // command queue
  mcspg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back end
  mcspg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .min_ticks   (min_ticks),
    .max_ticks   (max_ticks),
    .enable_mask (enable_mask),
    .frame_ticks (frame_ticks),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pin_levels  (pin_levels),
    .read_angle  (read_angle),
    .state       (bk_state)
  );

  // divider used by the back end
  mcspg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // divider finishes only while the back end waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> bk_state == mcspg_pkg::BK_DIV)
    else $error("divider finished outside the divide state");

  // the back end never waits on an idle divider
  a_div_active: assert property (@(posedge clk) disable iff (rst)
    bk_state == mcspg_pkg::BK_DIV |-> div_rsp.busy || div_rsp.done)
    else $error("back end waiting on an idle divider");

  // an accepted transaction is visible at the queue head side
  a_push_queued: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> q_valid)
    else $error("accepted transaction missing from queue");

  // a taken result is only replaced from the finishing state
  a_out_reload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && bk_state != mcspg_pkg::BK_DONE |=> !out_valid)
    else $error("result appeared without the back end finishing");

endmodule

// ===== tb/tb_multi_channel_servo_pulse_generator_top.sv =====
// self-checking testbench for multi_channel_servo_pulse_generator_top
// depends on mcspg_pkg and the top level; holds its own servo pulse predictor
`timescale 1ns / 1ps

module tb_multi_channel_servo_pulse_generator_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int WINDOW_TICKS  = 256;
  localparam int MAX_DEGREES   = 180;
  localparam int MAX_REPORTS   = 10;

  // one expected result: pin levels and read-back angle
  typedef struct {
    logic [mcspg_pkg::SLOTS-1:0]   pins;
    logic [mcspg_pkg::WIDTH_W-1:0] angle;
  } servo_result_t;

  // predicts servo state per transaction and checks results in order
  class servo_scoreboard;
    logic [mcspg_pkg::WIDTH_W-1:0] min_width;
    logic [mcspg_pkg::WIDTH_W-1:0] max_width;
    logic [mcspg_pkg::SLOTS-1:0]   enabled;
    logic [mcspg_pkg::FRAME_W-1:0] frame_len;
    logic [mcspg_pkg::WIDTH_W-1:0] width_of [mcspg_pkg::SLOTS];
    logic [mcspg_pkg::SLOTS-1:0]   pins_high;
    logic [mcspg_pkg::FRAME_W-1:0] frame_pos;
    servo_result_t                 awaited_q[$];
    int                            errors;
    int                            results_seen;

    function new();
      min_width = mcspg_pkg::MIN_TICKS_RESET;
      max_width = mcspg_pkg::MAX_TICKS_RESET;
      enabled   = mcspg_pkg::ENABLE_MASK_RESET;
      frame_len = mcspg_pkg::FRAME_TICKS_RESET;
      foreach (width_of[k]) width_of[k] = mcspg_pkg::DEFAULT_WIDTH;
      pins_high = '0;
      frame_pos = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_reg(mcspg_pkg::cfg_reg_t idx, logic [mcspg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mcspg_pkg::REG_MIN_TICKS:   min_width = data[mcspg_pkg::WIDTH_W-1:0];
        mcspg_pkg::REG_MAX_TICKS:   max_width = data[mcspg_pkg::WIDTH_W-1:0];
        mcspg_pkg::REG_ENABLE_MASK: enabled   = data[mcspg_pkg::SLOTS-1:0];
        mcspg_pkg::REG_FRAME_TICKS: frame_len = data[mcspg_pkg::FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    // clamp a width into min..max, min taking priority
    function int clamp_width(int w);
      if (w < int'(min_width)) return int'(min_width);
      if (w > int'(max_width)) return int'(max_width);
      return w;
    endfunction

    function void advance_frame();
      logic [mcspg_pkg::SLOTS-1:0] active;
      int                          next_pos;
      active = enabled & mcspg_pkg::CHAN_MASK;
      if (frame_pos == '0) pins_high = active;
      if (int'(frame_pos) < WINDOW_TICKS) begin
        for (int k = 0; k < mcspg_pkg::CHANNELS; k++) begin
          if (pins_high[k] && frame_pos >= mcspg_pkg::FRAME_W'(width_of[k]))
            pins_high[k] = 1'b0;
        end
      end else begin
        pins_high = '0;
      end
      pins_high &= active;
      next_pos = int'(frame_pos) + 1;
      if (next_pos >= int'(frame_len)) next_pos = 0;
      frame_pos = mcspg_pkg::FRAME_W'(next_pos);
    endfunction

    function logic [mcspg_pkg::WIDTH_W-1:0] angle_of(int ch);
      int span;
      int deg;
      span = int'(max_width) - int'(min_width);
      if (span <= 0) return '0;
      deg = (int'(width_of[ch]) + 1 - int'(min_width)) * MAX_DEGREES / span;
      if (deg < 0) deg = 0;
      if (deg > int'(mcspg_pkg::WIDTH_SAT)) deg = int'(mcspg_pkg::WIDTH_SAT);
      return mcspg_pkg::WIDTH_W'(deg);
    endfunction

    // accepted input transaction: update state, queue the result it causes
    function void predict_transaction(mcspg_pkg::op_t op,
                                      logic [mcspg_pkg::CHANNEL_W-1:0] ch,
                                      logic signed [mcspg_pkg::VALUE_W-1:0] val);
      servo_result_t r;
      int            v;
      int            a;
      logic          addressable;
      v = int'(val);
      addressable = int'(ch) < mcspg_pkg::CHANNELS;
      r.angle = '0;
      case (op)
        mcspg_pkg::OP_TICK: advance_frame();
        mcspg_pkg::OP_SET_ANGLE: begin
          if (addressable) begin
            a = v;
            if (a < 0) a = 0;
            if (a > MAX_DEGREES) a = MAX_DEGREES;
            a = int'(min_width) + a * (int'(max_width) - int'(min_width)) / MAX_DEGREES;
            width_of[ch] = mcspg_pkg::WIDTH_W'(clamp_width(a));
          end
        end
        mcspg_pkg::OP_SET_TICKS: begin
          if (addressable) width_of[ch] = mcspg_pkg::WIDTH_W'(clamp_width(v));
        end
        default: begin
          if (addressable) r.angle = angle_of(int'(ch));
        end
      endcase
      r.pins = pins_high;
      awaited_q.push_back(r);
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch on result %0d, %0s: expected %0d, got %0d",
                 results_seen, what, want, got);
    endfunction

    function void check_result(logic [mcspg_pkg::SLOTS-1:0] pins,
                               logic [mcspg_pkg::WIDTH_W-1:0] angle);
      servo_result_t r;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result %0d: pins %0h angle %0d", results_seen, pins, angle);
      end else begin
        r = awaited_q.pop_front();
        if (pins !== r.pins) flag("pin_levels", int'(r.pins), int'(pins));
        if (angle !== r.angle) flag("read_angle", int'(r.angle), int'(angle));
      end
      results_seen++;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [1:0]                           operation = mcspg_pkg::OP_TICK;
  logic [mcspg_pkg::CHANNEL_W-1:0]      channel = '0;
  logic signed [mcspg_pkg::VALUE_W-1:0] value = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [mcspg_pkg::SLOTS-1:0]          pin_levels;
  logic [mcspg_pkg::WIDTH_W-1:0]        read_angle;
  logic                                 cfg_write = 1'b0;
  logic [mcspg_pkg::CFG_INDEX_W-1:0]    cfg_index = mcspg_pkg::REG_MIN_TICKS;
  logic [mcspg_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;

  servo_scoreboard sb = new();

  multi_channel_servo_pulse_generator_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .channel    (channel),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pin_levels (pin_levels),
    .read_angle (read_angle),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result check on each accepted output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(pin_levels, read_angle);
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_multi_channel_servo_pulse_generator_top: errors");
    $finish;
  end

  // offer one transaction and wait until it is accepted
  task automatic send_item(input mcspg_pkg::op_t op,
                           input logic [mcspg_pkg::CHANNEL_W-1:0] ch,
                           input logic signed [mcspg_pkg::VALUE_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    channel   <= ch;
    value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_transaction(op, ch, val);
    @(negedge clk);
  endtask

  task automatic write_reg(input mcspg_pkg::cfg_reg_t idx,
                           input logic [mcspg_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int min_w, input int max_w, input int mask, input int frame);
    write_reg(mcspg_pkg::REG_MIN_TICKS, mcspg_pkg::CFG_DATA_W'(min_w));
    write_reg(mcspg_pkg::REG_MAX_TICKS, mcspg_pkg::CFG_DATA_W'(max_w));
    write_reg(mcspg_pkg::REG_ENABLE_MASK, mcspg_pkg::CFG_DATA_W'(mask));
    write_reg(mcspg_pkg::REG_FRAME_TICKS, mcspg_pkg::CFG_DATA_W'(frame));
  endtask

  // drain all results, then let the divider path go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [mcspg_pkg::VALUE_W-1:0] pick_value(mcspg_pkg::op_t op);
    int r;
    int v;
    r = $urandom_range(9);
    v = $urandom_range(2047);
    if (op == mcspg_pkg::OP_SET_ANGLE) begin
      if (r < 5) v = $urandom_range(MAX_DEGREES);
      else if (r < 7) v = $urandom_range(6) - 3;
      else if (r < 8) v = MAX_DEGREES - 3 + $urandom_range(6);
    end else if (op == mcspg_pkg::OP_SET_TICKS) begin
      if (r < 6) v = $urandom_range(255);
    end
    return mcspg_pkg::VALUE_W'(v);
  endfunction

  // mostly ticks so frames run through, with set and read commands mixed in
  task automatic run_random(input int count);
    mcspg_pkg::op_t op;
    int             r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 75) op = mcspg_pkg::OP_TICK;
      else if (r < 83) op = mcspg_pkg::OP_SET_ANGLE;
      else if (r < 91) op = mcspg_pkg::OP_SET_TICKS;
      else op = mcspg_pkg::OP_READ_ANGLE;
      send_item(op, mcspg_pkg::CHANNEL_W'($urandom_range(7)), pick_value(op));
    end
  endtask

  // main sequence
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset widths, angle and width clamping, every channel read back
    send_item(mcspg_pkg::OP_READ_ANGLE, 3'd0, 11'sd0);
    send_item(mcspg_pkg::OP_SET_ANGLE, 3'd0, -11'sd1024);
    send_item(mcspg_pkg::OP_SET_ANGLE, 3'd1, 11'sd1023);
    send_item(mcspg_pkg::OP_SET_ANGLE, 3'd2, 11'sd0);
    send_item(mcspg_pkg::OP_SET_ANGLE, 3'd3, 11'sd180);
    send_item(mcspg_pkg::OP_SET_ANGLE, 3'd4, 11'sd90);
    send_item(mcspg_pkg::OP_SET_TICKS, 3'd5, -11'sd1024);
    send_item(mcspg_pkg::OP_SET_TICKS, 3'd6, 11'sd1023);
    send_item(mcspg_pkg::OP_SET_TICKS, 3'd7, 11'sd100);
    send_item(mcspg_pkg::OP_SET_TICKS, 3'd2, 11'sd33);
    send_item(mcspg_pkg::OP_SET_TICKS, 3'd3, 11'sd151);
    for (int k = 0; k < mcspg_pkg::CHANNELS; k++)
      send_item(mcspg_pkg::OP_READ_ANGLE, mcspg_pkg::CHANNEL_W'(k), -11'sd1);
    send_item(mcspg_pkg::OP_TICK, 3'd7, -11'sd1);
    send_item(mcspg_pkg::OP_TICK, 3'd0, 11'sd0);
    settle();

    // full range, short frame, zero widths possible; long output hold-off
    configure(0, 255, 8'hFF, 257);
    send_item(mcspg_pkg::OP_SET_TICKS, 3'd0, 11'sd0);
    send_item(mcspg_pkg::OP_SET_TICKS, 3'd1, 11'sd1);
    hold_req = 1'b1;
    run_random(180);
    settle();

    // narrow range, random channel set, sender mostly idle
    configure(20, 60, $urandom_range(255), 300);
    idle_pct = 86;
    run_random(170);
    settle();

    // longest frame, partial mask, receiver mostly stalled
    configure(40, 100, 8'hA5, 4095);
    idle_pct = 0;
    stall_pct = 86;
    run_random(120);
    settle();

    // max below min, frame held at count zero
    configure(255, 0, 8'hFF, 0);
    idle_pct = 27;
    stall_pct = 27;
    run_random(60);
    settle();

    // back to default range with light idling on both sides
    configure(34, 150, 8'hFF, 257);
    run_random(150);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_multi_channel_servo_pulse_generator_top: clean");
    end else begin
      $display("tb_multi_channel_servo_pulse_generator_top: errors");
    end
    $finish;
  end

endmodule
